// ===== sv/lrt_pkg.sv =====
`default_nettype none

package lrt_pkg;

  localparam int unsigned ENTRIES = 32;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Request codes.
  localparam logic [2:0] REQ_LOOKUP  = 3'd0;
  localparam logic [2:0] REQ_SET     = 3'd1;
  localparam logic [2:0] REQ_DELETE  = 3'd2;
  localparam logic [2:0] REQ_REFRESH = 3'd3;
  localparam logic [2:0] REQ_TICK    = 3'd4;

  // Status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_INVALID_TICKS = 2'd0;
  localparam logic [1:0] CFG_FLUSH_TICKS   = 2'd1;
  localparam logic [1:0] CFG_MAX_DISTANCE  = 2'd2;

  localparam logic [15:0] INVALID_TICKS_RST = 16'd180;
  localparam logic [15:0] FLUSH_TICKS_RST   = 16'd120;
  localparam logic [7:0]  MAX_DISTANCE_RST  = 8'd16;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] address;
    logic [31:0] netmask;
    logic [31:0] hop_in;
    logic [7:0]  metric;
  } req_t;

  typedef struct packed {
    logic [31:0] hop_out;
    logic        hit;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [7:0]  distance;
    logic [15:0] live_timer;
    logic [15:0] purge_timer;
    logic        valid;
  } entry_t;

endpackage

`default_nettype wire

// ===== sv/lpm_route_table_with_aging_core.sv =====
`default_nettype none

// Longest-prefix-match route table with distance-vector style aging.
//
// A request beat (lookup, set, delete, refresh or tick) is taken on req_i at a
// rising edge where start is high and busy is low. Every request gives exactly
// one response beat on rsp_o, marked by done_o for a single cycle; the receiver
// cannot stall it, so it must take the beat in that cycle.
// The entries live in one synchronous memory of ENTRIES words with a registered
// read; only the per-entry used marks are flip-flops, cleared at reset,
// so the block is ready straight after reset with no clearing pass.
// Each request scans the whole memory through its single read port, one entry
// per cycle in index order. While busy is high the block issues every read,
// waits for the last read to return, and in a closing state writes a set or
// refresh entry back. done_o rises in the cycle after busy falls, and start is
// honoured in that same cycle, so the next request can be taken while the last
// response beat is shown. A tick writes each aged entry back in the cycle after
// it is read, so the read and write never meet on the same entry.
// Configuration writes go straight into the registers through cfg_we_i,
// cfg_idx_i and cfg_wdata_i and are meant for idle periods only.
// Reset loads the default timer and distance registers and empties the table.

module lpm_route_table_with_aging_core
  import lrt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output      logic        busy,
  input  wire req_t        req_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  output      logic        done_o,
  output      rsp_t        rsp_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_e state_q, state_d;

  // Configuration registers.
  logic [15:0] invalid_ticks_q, invalid_ticks_d;
  logic [15:0] flush_ticks_q, flush_ticks_d;
  logic [7:0]  max_distance_q, max_distance_d;

  // Used marks, one flip-flop per entry.
  logic [ENTRIES-1:0] used_q, used_d;

  // Scan control.
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             issue_q, issue_d;
  logic             eval_vld_q, eval_vld_d;
  logic [IDX_W-1:0] eval_idx_q, eval_idx_d;

  // Request held for the whole scan, and what the scan has gathered.
  req_t             req_q, req_d;
  logic [31:0]      best_q, best_d;
  logic [31:0]      hop_q, hop_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic             free_found_q, free_found_d;
  logic [IDX_W-1:0] free_slot_q, free_slot_d;
  entry_t           saved_q, saved_d;

  // Response register.
  logic done_q, done_d;
  rsp_t rsp_q, rsp_d;

  // Entry memory.
  entry_t           mem_q [ENTRIES];
  entry_t           rd_data_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  // Per-entry checks on the word that has just come back from memory.
  entry_t rd_e;
  entry_t aged_e;
  logic   rd_used;
  logic   exact_hit;
  logic   lpm_hit;
  logic   refresh_hit;
  logic   flush_expired;

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[cnt_q];
  end

  assign rd_e    = rd_data_q;
  assign rd_used = used_q[eval_idx_q];

  assign exact_hit = rd_used && (rd_e.prefix == req_q.address) &&
                     (rd_e.mask == req_q.netmask);
  assign lpm_hit   = rd_used && (rd_e.prefix == (rd_e.mask & req_q.address)) &&
                     (rd_e.mask > best_q);
  assign refresh_hit = rd_used && (rd_e.mask == req_q.netmask) &&
                       ((req_q.address & rd_e.mask) == (rd_e.prefix & rd_e.mask));

  // Aging of one entry. A valid entry counts its live timer down and turns
  // invalid at zero; an invalid entry counts its flush timer down instead.
  always_comb begin
    aged_e        = rd_e;
    flush_expired = 1'b0;
    if (rd_e.valid) begin
      aged_e.live_timer = rd_e.live_timer - 16'd1;
      if (aged_e.live_timer == 16'd0) begin
        aged_e.valid    = 1'b0;
        aged_e.distance = max_distance_q;
      end
    end else begin
      aged_e.purge_timer = rd_e.purge_timer - 16'd1;
      flush_expired      = (aged_e.purge_timer == 16'd0);
    end
  end

  always_comb begin
    state_d         = state_q;
    invalid_ticks_d = invalid_ticks_q;
    flush_ticks_d   = flush_ticks_q;
    max_distance_d  = max_distance_q;
    used_d          = used_q;
    cnt_d           = cnt_q;
    issue_d         = issue_q;
    eval_vld_d      = 1'b0;
    eval_idx_d      = eval_idx_q;
    req_d           = req_q;
    best_d          = best_q;
    hop_d           = hop_q;
    found_d         = found_q;
    slot_d          = slot_q;
    free_found_d    = free_found_q;
    free_slot_d     = free_slot_q;
    saved_d         = saved_q;
    done_d          = 1'b0;
    rsp_d           = rsp_q;
    mem_we          = 1'b0;
    mem_waddr       = eval_idx_q;
    mem_wdata       = aged_e;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INVALID_TICKS: invalid_ticks_d = cfg_wdata_i;
        CFG_FLUSH_TICKS:   flush_ticks_d   = cfg_wdata_i;
        CFG_MAX_DISTANCE:  max_distance_d  = cfg_wdata_i[7:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d      = ST_SCAN;
          req_d        = req_i;
          cnt_d        = '0;
          issue_d      = 1'b1;
          best_d       = '0;
          hop_d        = '1;
          found_d      = 1'b0;
          free_found_d = 1'b0;
        end
      end

      ST_SCAN: begin
        // Issue side: one memory read per cycle.
        eval_vld_d = issue_q;
        eval_idx_d = cnt_q;
        if (issue_q) begin
          if (cnt_q == LAST_IDX) begin
            issue_d = 1'b0;
          end else begin
            cnt_d = cnt_q + IDX_W'(1);
          end
        end

        // Evaluation side: the word read in the previous cycle.
        if (eval_vld_q) begin
          if (!rd_used && !free_found_q) begin
            free_found_d = 1'b1;
            free_slot_d  = eval_idx_q;
          end
          case (req_q.req_type) inside
            REQ_LOOKUP: begin
              if (lpm_hit) begin
                best_d = rd_e.mask;
                hop_d  = rd_e.gateway;
              end
            end
            REQ_SET, REQ_DELETE: begin
              if (exact_hit && !found_q) begin
                found_d = 1'b1;
                slot_d  = eval_idx_q;
              end
            end
            REQ_REFRESH: begin
              if (refresh_hit && !found_q) begin
                found_d = 1'b1;
                slot_d  = eval_idx_q;
                saved_d = rd_e;
              end
            end
            REQ_TICK: begin
              if (rd_used) begin
                mem_we = 1'b1;
                if (flush_expired) begin
                  used_d[eval_idx_q] = 1'b0;
                end
              end
            end
            default: ;
          endcase
          if (eval_idx_q == LAST_IDX) begin
            state_d = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        rsp_d   = '0;
        case (req_q.req_type)
          REQ_LOOKUP: begin
            rsp_d.hop_out = hop_q;
            if (best_q != 32'd0) begin
              rsp_d.hit = 1'b1;
            end else begin
              rsp_d.status = STATUS_NOT_FOUND;
            end
          end
          REQ_SET: begin
            if (found_q || free_found_q) begin
              mem_we                = 1'b1;
              mem_waddr             = found_q ? slot_q : free_slot_q;
              mem_wdata.prefix      = req_q.address;
              mem_wdata.mask        = req_q.netmask;
              mem_wdata.gateway     = req_q.hop_in;
              mem_wdata.distance    = req_q.metric;
              mem_wdata.purge_timer = flush_ticks_q;
              if (req_q.metric == max_distance_q) begin
                mem_wdata.live_timer = 16'd0;
                mem_wdata.valid      = 1'b0;
              end else begin
                mem_wdata.live_timer = invalid_ticks_q;
                mem_wdata.valid      = 1'b1;
              end
              used_d[mem_waddr] = 1'b1;
            end else begin
              rsp_d.status = STATUS_FULL;
            end
          end
          REQ_DELETE: begin
            if (found_q) begin
              used_d[slot_q] = 1'b0;
            end else begin
              rsp_d.status = STATUS_NOT_FOUND;
            end
          end
          REQ_REFRESH: begin
            if (found_q) begin
              mem_we                = 1'b1;
              mem_waddr             = slot_q;
              mem_wdata             = saved_q;
              mem_wdata.purge_timer = flush_ticks_q;
              mem_wdata.live_timer  = invalid_ticks_q;
              mem_wdata.valid       = 1'b1;
              mem_wdata.distance    = req_q.metric;
              rsp_d.hit             = 1'b1;
            end else begin
              rsp_d.status = STATUS_NOT_FOUND;
            end
          end
          default: ;
        endcase
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      invalid_ticks_q <= INVALID_TICKS_RST;
      flush_ticks_q   <= FLUSH_TICKS_RST;
      max_distance_q  <= MAX_DISTANCE_RST;
      used_q          <= '0;
      issue_q         <= 1'b0;
      eval_vld_q      <= 1'b0;
      done_q          <= 1'b0;
    end else begin
      state_q         <= state_d;
      invalid_ticks_q <= invalid_ticks_d;
      flush_ticks_q   <= flush_ticks_d;
      max_distance_q  <= max_distance_d;
      used_q          <= used_d;
      issue_q         <= issue_d;
      eval_vld_q      <= eval_vld_d;
      done_q          <= done_d;
    end
  end

  // Payload and scan registers need no reset: each request loads them first.
  always_ff @(posedge clk_i) begin
    cnt_q        <= cnt_d;
    eval_idx_q   <= eval_idx_d;
    req_q        <= req_d;
    best_q       <= best_d;
    hop_q        <= hop_d;
    found_q      <= found_d;
    slot_q       <= slot_d;
    free_found_q <= free_found_d;
    free_slot_q  <= free_slot_d;
    saved_q      <= saved_d;
    rsp_q        <= rsp_d;
  end

endmodule

`default_nettype wire

// ===== tb/tb_lpm_route_table_with_aging_core.sv =====
`timescale 1ns / 100ps

module tb_lpm_route_table_with_aging_core
  import lrt_pkg::*;
;

  // Request codes above tick are unused by the block: it must answer them with
  // an all-zero response and leave the table alone.
  localparam logic [2:0] REQ_FIRST_UNUSED = REQ_TICK + 3'd1;
  localparam logic [2:0] REQ_LAST_CODE    = 3'b111;
  localparam int         POOL_MAX         = 48;
  // The quiet period at the end of the run allows more than a full scan of
  // ENTRIES reads for any stray response beat.
  localparam int         QUIET_CYCLES     = ENTRIES + 8;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  req_t        req_i       = '0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = CFG_INVALID_TICKS;
  logic [15:0] cfg_wdata_i = '0;
  logic        busy;
  logic        done_o;
  rsp_t        rsp_o;

  lpm_route_table_with_aging_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

  initial forever #10 clk_i = ~clk_i;

  // A generous ceiling: about 520 requests, plus idle gaps, come to well below
  // a tenth of this.
  initial begin
    #10ms;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shadow route table. It mirrors the block's table and registers and is
  // advanced once for every request beat the block accepts.
  // ---------------------------------------------------------------------------
  logic        rt_used [ENTRIES];
  entry_t      rt_entry [ENTRIES];
  logic [15:0] live_load   = INVALID_TICKS_RST;
  logic [15:0] flush_load  = FLUSH_TICKS_RST;
  logic [7:0]  unreachable = MAX_DISTANCE_RST;

  // Run statistics for the closing summary.
  int beats_sent    = 0;
  int lookup_hits   = 0;
  int refresh_hits  = 0;
  int full_refusals = 0;
  int aged_out      = 0;
  int mismatches    = 0;

  initial begin
    foreach (rt_used[i]) begin
      rt_used[i] = 1'b0;
    end
  end

  // Slot holding exactly this prefix and mask, or -1.
  function automatic int find_route(input logic [31:0] pfx, input logic [31:0] msk);
    for (int i = 0; i < ENTRIES; i++) begin
      if (rt_used[i] && rt_entry[i].prefix == pfx && rt_entry[i].mask == msk) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Works out the response to one request and applies its effect on the table.
  function automatic rsp_t route_response(input req_t rq);
    rsp_t        rs;
    logic [31:0] best;
    int          slot;
    rs = '0;
    case (rq.req_type)
      REQ_LOOKUP: begin
        // Longest mask wins, compared as an unsigned number; a default route
        // with a zero mask can never win, and on a tie the lowest slot stays.
        best = '0;
        rs.hop_out = '1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (rt_used[i] && rt_entry[i].prefix == (rt_entry[i].mask & rq.address) &&
              rt_entry[i].mask > best) begin
            best = rt_entry[i].mask;
            rs.hop_out = rt_entry[i].gateway;
          end
        end
        if (best != '0) begin
          rs.hit = 1'b1;
          lookup_hits++;
        end else begin
          rs.status = STATUS_NOT_FOUND;
        end
      end
      REQ_SET: begin
        slot = find_route(rq.address, rq.netmask);
        if (slot < 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (!rt_used[i] && slot < 0) begin
              slot = i;
            end
          end
        end
        if (slot < 0) begin
          rs.status = STATUS_FULL;
          full_refusals++;
        end else begin
          rt_used[slot]              = 1'b1;
          rt_entry[slot].prefix      = rq.address;
          rt_entry[slot].mask        = rq.netmask;
          rt_entry[slot].gateway     = rq.hop_in;
          rt_entry[slot].distance    = rq.metric;
          rt_entry[slot].purge_timer = flush_load;
          // A route announced at the unreachable distance goes in already
          // invalid, so it only waits out its flush period.
          if (rq.metric == unreachable) begin
            rt_entry[slot].live_timer = '0;
            rt_entry[slot].valid      = 1'b0;
          end else begin
            rt_entry[slot].live_timer = live_load;
            rt_entry[slot].valid      = 1'b1;
          end
        end
      end
      REQ_DELETE: begin
        slot = find_route(rq.address, rq.netmask);
        if (slot < 0) begin
          rs.status = STATUS_NOT_FOUND;
        end else begin
          rt_used[slot] = 1'b0;
        end
      end
      REQ_REFRESH: begin
        rs.status = STATUS_NOT_FOUND;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && rt_used[i] && rt_entry[i].mask == rq.netmask &&
              (rq.address & rt_entry[i].mask) == (rt_entry[i].prefix & rt_entry[i].mask)) begin
            slot = i;
          end
        end
        if (slot >= 0) begin
          rt_entry[slot].purge_timer = flush_load;
          rt_entry[slot].live_timer  = live_load;
          rt_entry[slot].valid       = 1'b1;
          rt_entry[slot].distance    = rq.metric;
          rs.hit    = 1'b1;
          rs.status = STATUS_OK;
          refresh_hits++;
        end
      end
      REQ_TICK: begin
        // Valid routes count down to invalid; invalid ones count down to
        // removal. Both timers wrap at zero as 16-bit counters.
        for (int i = 0; i < ENTRIES; i++) begin
          if (rt_used[i]) begin
            if (rt_entry[i].valid) begin
              rt_entry[i].live_timer = rt_entry[i].live_timer - 16'd1;
              if (rt_entry[i].live_timer == '0) begin
                rt_entry[i].valid    = 1'b0;
                rt_entry[i].distance = unreachable;
              end
            end else begin
              rt_entry[i].purge_timer = rt_entry[i].purge_timer - 16'd1;
              if (rt_entry[i].purge_timer == '0) begin
                rt_used[i] = 1'b0;
                aged_out++;
              end
            end
          end
        end
      end
      default: begin
        // Unused request codes: nothing changes and the response stays zero.
      end
    endcase
    return rs;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. Request beats come from the backlog that the sequence below fills.
  // A raised start is held until the block takes the beat; otherwise the sender
  // may sit idle at the current idle percentage, so gaps land at every point of
  // the block's scan.
  // ---------------------------------------------------------------------------
  req_t request_backlog[$];
  rsp_t awaited_responses[$];
  int   sender_idle_pct = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        awaited_responses.insert(awaited_responses.size(), route_response(req_i));
        beats_sent++;
      end
      if (start && busy) begin
        // Beat still waiting to be taken: hold start and the payload.
      end else if (request_backlog.size() != 0 &&
                   $urandom_range(0, 99) >= sender_idle_pct) begin
        start <= 1'b1;
        req_i <= request_backlog.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. done_o marks a response beat for a single cycle; it is taken at
  // the edge that closes that cycle and compared with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (awaited_responses.size() == 0) begin
        $error("response beat with nothing outstanding: hop_out %h hit %b status %0d",
               rsp_o.hop_out, rsp_o.hit, rsp_o.status);
        mismatches++;
      end else begin
        want = awaited_responses.pop_front();
        if (rsp_o.hop_out !== want.hop_out) begin
          $error("hop_out: expected %h, got %h", want.hop_out, rsp_o.hop_out);
          mismatches++;
        end
        if (rsp_o.hit !== want.hit) begin
          $error("hit: expected %b, got %b", want.hit, rsp_o.hit);
          mismatches++;
        end
        if (rsp_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_o.status);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence helpers.
  // ---------------------------------------------------------------------------
  function automatic req_t make_req(input logic [2:0] op, input logic [31:0] addr,
                                    input logic [31:0] msk, input logic [31:0] hop,
                                    input logic [7:0] met);
    req_t rq;
    rq.req_type = op;
    rq.address  = addr;
    rq.netmask  = msk;
    rq.hop_in   = hop;
    rq.metric   = met;
    return rq;
  endfunction

  // Appends one request beat to the end of the backlog.
  function automatic void queue_req(input req_t rq);
    request_backlog.insert(request_backlog.size(), rq);
  endfunction

  // Blocks until the backlog is empty, the last beat has been taken and every
  // response has come back. Sampled on the falling edge so that the driver and
  // the monitor have settled for the cycle.
  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (request_backlog.size() != 0 || start || awaited_responses.size() != 0);
  endtask

  // Register writes only happen while the block is idle, so the shadow copy
  // can be updated at once.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_INVALID_TICKS: live_load = value;
      CFG_FLUSH_TICKS:   flush_load = value;
      CFG_MAX_DISTANCE:  unreachable = value[7:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Routes that the random requests of one phase revolve around. Many share a
  // stem with an earlier route so that lookups see nested prefixes, a few have
  // ragged masks or host bits left in the prefix, and the pool is larger than
  // the table so that it can fill up.
  logic [31:0] pool_prefix [POOL_MAX];
  logic [31:0] pool_mask   [POOL_MAX];

  task automatic build_pool();
    int          len;
    logic [31:0] stem;
    for (int k = 0; k < POOL_MAX; k++) begin
      len = $urandom_range(0, 32);
      pool_mask[k] = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
      if ($urandom_range(0, 9) == 0) begin
        pool_mask[k] = $urandom;
      end
      stem = (k > 0 && $urandom_range(0, 1) == 1) ?
             pool_prefix[$urandom_range(0, k - 1)] : $urandom;
      pool_prefix[k] = (stem ^ ($urandom & ~(pool_mask[k] << 4))) & pool_mask[k];
      if ($urandom_range(0, 19) == 0) begin
        pool_prefix[k] = $urandom;
      end
    end
  endtask

  function automatic logic [7:0] pick_metric();
    return ($urandom_range(0, 3) == 0) ? unreachable : 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_random(input int count);
    int          k;
    int          r;
    logic [31:0] dest;
    for (int n = 0; n < count; n++) begin
      k    = $urandom_range(0, POOL_MAX - 1);
      r    = $urandom_range(0, 99);
      dest = ($urandom_range(0, 9) < 7) ?
             (pool_prefix[k] | ($urandom & ~pool_mask[k])) : $urandom;
      if (r < 4) begin
        queue_req(make_req(3'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_CODE)),
                           $urandom, $urandom, $urandom, 8'($urandom)));
      end else if (r < 30) begin
        queue_req(make_req(REQ_LOOKUP, dest, $urandom, $urandom, 8'($urandom)));
      end else if (r < 57) begin
        queue_req(make_req(REQ_SET, pool_prefix[k], pool_mask[k], $urandom,
                           pick_metric()));
      end else if (r < 67) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_req(make_req(REQ_DELETE, $urandom, $urandom, $urandom, 8'($urandom)));
        end else begin
          queue_req(make_req(REQ_DELETE, pool_prefix[k], pool_mask[k], $urandom,
                             8'($urandom)));
        end
      end else if (r < 82) begin
        queue_req(make_req(REQ_REFRESH, dest,
                           ($urandom_range(0, 9) == 0) ? $urandom : pool_mask[k],
                           $urandom, pick_metric()));
      end else begin
        queue_req(make_req(REQ_TICK, $urandom, $urandom, $urandom, 8'($urandom)));
      end
    end
  endtask

  // One random phase: new register values, a fresh route pool, and halfway
  // through a pause in which the sender waits for every response to arrive.
  task automatic run_phase(input logic [15:0] inv, input logic [15:0] flush,
                           input logic [7:0] maxd, input int idle_pct, input int count);
    write_reg(CFG_INVALID_TICKS, inv);
    write_reg(CFG_FLUSH_TICKS, flush);
    write_reg(CFG_MAX_DISTANCE, {8'h00, maxd});
    sender_idle_pct = idle_pct;
    build_pool();
    queue_random(count / 2);
    wait_drained();
    queue_random(count - count / 2);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats at the reset register values (distance 16 unreachable).
    // Empty table: a lookup misses with an all-ones next hop.
    queue_req(make_req(REQ_LOOKUP, 32'h0, 32'h0, 32'h0, 8'h0));
    // Nested routes, a default route and a host route with every bit set.
    queue_req(make_req(REQ_SET, 32'h0A00_0000, 32'hFF00_0000, 32'hC0A8_0001, 8'd1));
    queue_req(make_req(REQ_SET, 32'h0A01_0000, 32'hFFFF_0000, 32'hC0A8_0002, 8'd2));
    queue_req(make_req(REQ_SET, 32'h0, 32'h0, 32'hC0A8_0003, 8'd0));
    queue_req(make_req(REQ_SET, '1, '1, '1, 8'hFF));
    queue_req(make_req(REQ_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 8'h0));
    queue_req(make_req(REQ_LOOKUP, 32'h0A02_0000, '1, '1, 8'hFF));
    // Only the default route covers this one, and a zero mask is never chosen.
    queue_req(make_req(REQ_LOOKUP, 32'h0B00_0000, 32'h0, 32'h0, 8'h0));
    queue_req(make_req(REQ_LOOKUP, '1, 32'h0, 32'h0, 8'h0));
    // Overwrite at the unreachable distance: stored invalid but still looked up.
    queue_req(make_req(REQ_SET, 32'h0A00_0000, 32'hFF00_0000, 32'hC0A8_0009, 8'd16));
    queue_req(make_req(REQ_LOOKUP, 32'h0A7F_0001, 32'h0, 32'h0, 8'h0));
    // Refresh through any address in the subnet, then with a mask that differs.
    queue_req(make_req(REQ_REFRESH, 32'h0AC8_0000, 32'hFF00_0000, 32'h0, 8'd0));
    queue_req(make_req(REQ_REFRESH, 32'h0A01_0000, 32'hFFFF_FF00, 32'h0, 8'd3));
    queue_req(make_req(REQ_REFRESH, 32'h0A01_0505, 32'hFFFF_0000, 32'h0, 8'd16));
    queue_req(make_req(REQ_DELETE, 32'h0A01_0000, 32'hFFFF_0000, 32'h0, 8'h0));
    queue_req(make_req(REQ_DELETE, 32'h0A01_0000, 32'hFFFF_0000, 32'h0, 8'h0));
    // A prefix with host bits set is stored as given and so never matches.
    queue_req(make_req(REQ_SET, 32'h0A01_0203, 32'hFFFF_0000, 32'hC0A8_0004, 8'd5));
    queue_req(make_req(REQ_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 8'h0));
    queue_req(make_req(REQ_TICK, '1, '1, '1, 8'hFF));
    queue_req(make_req(REQ_TICK, 32'h0, 32'h0, 32'h0, 8'h0));
    queue_req(make_req(REQ_FIRST_UNUSED, 32'h0, 32'h0, 32'h0, 8'h0));
    queue_req(make_req(REQ_LAST_CODE, '1, '1, '1, 8'hFF));
    queue_req(make_req(REQ_LOOKUP, 32'h0A00_0001, 32'h0, 32'h0, 8'h0));
    wait_drained();

    // Random phases. Short timers make routes expire and flush within a
    // handful of ticks; the extreme settings follow, the highest with the
    // sender idling at 23 percent.
    run_phase(16'd3,     16'd2,     8'd16,  0,  140);
    run_phase(16'd1,     16'd1,     8'd1,   51, 120);
    run_phase(16'd65535, 16'd65535, 8'd255, 23, 110);
    run_phase(16'd5,     16'd4,     8'd200, 51, 130);

    wait_drained();
    repeat (QUIET_CYCLES) @(posedge clk_i);
    if (awaited_responses.size() != 0) begin
      $error("%0d responses never arrived", awaited_responses.size());
      mismatches++;
    end

    $display("Run covered %0d request beats: %0d lookup hits, %0d refresh hits,",
             beats_sent, lookup_hits, refresh_hits);
    $display("%0d sets refused on a full table and %0d routes flushed by ageing.",
             full_refusals, aged_out);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
